@@ sv/lbf_pkg.sv @@
// ----------------------------------------------------------------------------
// lbf_pkg: shared definitions for the letterbox fit block
// Default widths and the configuration register map.
// ----------------------------------------------------------------------------
package lbf_pkg;

   localparam int COORD_BITS_DEF  = 16;
   localparam int ASPECT_BITS_DEF = 16;
   localparam int DIM_BITS        = 14;
   localparam int CSR_INDEX_BITS  = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VIDEO_WIDTH  = 3'd0,
      CSR_VIDEO_HEIGHT = 3'd1,
      CSR_ASPECT_NUM   = 3'd2,
      CSR_ASPECT_DEN   = 3'd3,
      CSR_TRANSPOSED   = 3'd4,
      CSR_KEEP_ASPECT  = 3'd5
   } csr_index_type;

endpackage

@@ sv/aspect_ratio_letterbox_fit_top.sv @@
// ----------------------------------------------------------------------------
// aspect_ratio_letterbox_fit_top: letterbox fit of a rectangle
// Gives the largest centered inner rectangle of the outer one that keeps
// the video display aspect ratio, or the outer one itself when bypassed.
//
//   channel   ports                    handshake
//   request   req_outer_*              start high, busy low
//   response  rsp_inner_*              rsp_valid strobe, one cycle
//   config    csr_we/index/wdata       csr_we high, no wait
//
// One beat enters per cycle; its response passes through stage 1, stage 2,
// stage 3, the divider, one quotient bit per stage, and the output register.
// Reset clears all valid bits and loads the register reset values.
// busy never rises and the receiver cannot stall, so the pipeline always
// advances.
// ----------------------------------------------------------------------------
module aspect_ratio_letterbox_fit_top
   import lbf_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int ASPECT_BITS = ASPECT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [COORD_BITS-1:0] req_outer_left,
   input  logic signed [COORD_BITS-1:0] req_outer_top,
   input  logic signed [COORD_BITS-1:0] req_outer_right,
   input  logic signed [COORD_BITS-1:0] req_outer_bottom,
   output logic rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_inner_left,
   output logic signed [COORD_BITS-1:0] rsp_inner_top,
   output logic signed [COORD_BITS-1:0] rsp_inner_right,
   output logic signed [COORD_BITS-1:0] rsp_inner_bottom,
   input  logic csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((ASPECT_BITS > DIM_BITS) ? ASPECT_BITS : DIM_BITS)-1:0] csr_wdata
);

   localparam int C = COORD_BITS;
   localparam int D = DIM_BITS + ASPECT_BITS;
   localparam int P = C + D;

   typedef struct packed {
      logic [C-1:0] left;
      logic [C-1:0] top;
      logic [C-1:0] right;
      logic [C-1:0] bottom;
      logic [C-1:0] outw;
      logic [C-1:0] outh;
      logic         pass;
      logic         by_height;
   } side_type;

   // Configuration registers.
   logic [DIM_BITS-1:0]    vid_w_ff, vid_h_ff;
   logic [ASPECT_BITS-1:0] par_num_ff, par_den_ff;
   logic                   transposed_ff, keep_aspect_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vid_w_ff       <= '0;
         vid_h_ff       <= '0;
         par_num_ff     <= ASPECT_BITS'(1);
         par_den_ff     <= ASPECT_BITS'(1);
         transposed_ff  <= 1'b0;
         keep_aspect_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIDEO_WIDTH:  vid_w_ff       <= csr_wdata[DIM_BITS-1:0];
            CSR_VIDEO_HEIGHT: vid_h_ff       <= csr_wdata[DIM_BITS-1:0];
            CSR_ASPECT_NUM:   par_num_ff     <= csr_wdata[ASPECT_BITS-1:0];
            CSR_ASPECT_DEN:   par_den_ff     <= csr_wdata[ASPECT_BITS-1:0];
            CSR_TRANSPOSED:   transposed_ff  <= csr_wdata[0];
            CSR_KEEP_ASPECT:  keep_aspect_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // Stage 1: outer size, bypass decision and raw display ratio terms.
   logic [C:0] w_in, h_in;
   logic       pass_in;
   side_type   s1_in, s1_ff;
   logic [D-1:0] dn1_in, dd1_in, dn1_ff, dd1_ff;
   logic         v1_ff;

   always_comb begin
      w_in = {req_outer_right[C-1], req_outer_right} - {req_outer_left[C-1], req_outer_left};
      h_in = {req_outer_bottom[C-1], req_outer_bottom} - {req_outer_top[C-1], req_outer_top};
      pass_in = ~keep_aspect_ff || (vid_w_ff == '0) || (vid_h_ff == '0) ||
                (par_num_ff == '0) || (par_den_ff == '0) || h_in[C] || (h_in == '0);
      s1_in.left      = req_outer_left;
      s1_in.top       = req_outer_top;
      s1_in.right     = req_outer_right;
      s1_in.bottom    = req_outer_bottom;
      // A negative outer width counts as zero.
      s1_in.outw      = (w_in[C] || (w_in == '0)) ? '0 : w_in[C-1:0];
      s1_in.outh      = h_in[C-1:0];
      s1_in.pass      = pass_in;
      s1_in.by_height = 1'b0;
      dn1_in = D'(vid_w_ff) * D'(par_num_ff);
      dd1_in = D'(vid_h_ff) * D'(par_den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
      s1_ff  <= s1_in;
      dn1_ff <= dn1_in;
      dd1_ff <= dd1_in;
   end

   // Stage 2: cross products for the fit direction.
   logic [D-1:0] dn2_in, dd2_in, dn2_ff, dd2_ff;
   logic [P-1:0] pw2_in, ph2_in, pw2_ff, ph2_ff;
   side_type     s2_ff;
   logic         v2_ff;

   always_comb begin
      dn2_in = transposed_ff ? dd1_ff : dn1_ff;
      dd2_in = transposed_ff ? dn1_ff : dd1_ff;
      pw2_in = P'(s1_ff.outw) * P'(dd2_in);
      ph2_in = P'(dn2_in) * P'(s1_ff.outh);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      s2_ff  <= s1_ff;
      dn2_ff <= dn2_in;
      dd2_ff <= dd2_in;
      pw2_ff <= pw2_in;
      ph2_ff <= ph2_in;
   end

   // Stage 3 and divider: the quotient never exceeds the outer size, so
   // C steps starting from the high part of the dividend are enough.
   logic [D-1:0] rem_ff [C+1];
   logic [C-1:0] quo_ff [C+1];
   logic [D-1:0] dvs_ff [C+1];
   side_type     sd_ff  [C+1];
   logic         vd_ff  [C+1];
   logic         by_h3;
   logic [P-1:0] num3;
   side_type     s3_in;

   always_comb begin
      by_h3 = (pw2_ff >= ph2_ff);
      num3  = by_h3 ? ph2_ff : pw2_ff;
      s3_in = s2_ff;
      s3_in.by_height = by_h3;
   end

   always_ff @(posedge clock) begin
      if (reset) vd_ff[0] <= 1'b0;
      else       vd_ff[0] <= v2_ff;
      rem_ff[0] <= num3[P-1:C];
      quo_ff[0] <= num3[C-1:0];
      dvs_ff[0] <= by_h3 ? dd2_ff : dn2_ff;
      sd_ff[0]  <= s3_in;
   end

   for (genvar k = 0; k < C; k++) begin : g_div
      logic [D-1:0] rem_in;
      logic [C-1:0] quo_in;

      lbf_div_step #(.REM_BITS(D), .QUO_BITS(C)) u_step (
         .rem_i     (rem_ff[k]),
         .quo_i     (quo_ff[k]),
         .divisor_i (dvs_ff[k]),
         .rem_o     (rem_in),
         .quo_o     (quo_in)
      );

      always_ff @(posedge clock) begin
         if (reset) vd_ff[k+1] <= 1'b0;
         else       vd_ff[k+1] <= vd_ff[k];
         rem_ff[k+1] <= rem_in;
         quo_ff[k+1] <= quo_in;
         dvs_ff[k+1] <= dvs_ff[k];
         sd_ff[k+1]  <= sd_ff[k];
      end
   end

   // Output stage: centering and bypass.
   side_type     sf;
   logic [C-1:0] iw, ih, x1, y1;
   logic [C-1:0] left_in, top_in, right_in, bottom_in;
   logic [C-1:0] rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;
   logic         rsp_valid_ff;

   always_comb begin
      sf = sd_ff[C];
      iw = sf.by_height ? quo_ff[C] : sf.outw;
      ih = sf.by_height ? sf.outh : quo_ff[C];
      x1 = sf.left + ((sf.outw - iw) >> 1);
      y1 = sf.top + ((sf.outh - ih) >> 1);
      if (sf.pass) begin
         left_in   = sf.left;
         top_in    = sf.top;
         right_in  = sf.right;
         bottom_in = sf.bottom;
      end else begin
         left_in   = x1;
         top_in    = y1;
         right_in  = x1 + iw;
         bottom_in = y1 + ih;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= vd_ff[C];
      rsp_left_ff   <= left_in;
      rsp_top_ff    <= top_in;
      rsp_right_ff  <= right_in;
      rsp_bottom_ff <= bottom_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inner_left   = rsp_left_ff;
   assign rsp_inner_top    = rsp_top_ff;
   assign rsp_inner_right  = rsp_right_ff;
   assign rsp_inner_bottom = rsp_bottom_ff;

   // Every accepted beat comes out as a response beat, and nothing else does.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(C+4) rsp_valid) else $error("response beat missing");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##(C+4) !rsp_valid) else $error("unexpected response beat");
   // The final remainder of a fitted beat is below its divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (vd_ff[C] && !sd_ff[C].pass) |-> (rem_ff[C] < dvs_ff[C]))
      else $error("divider remainder out of range");

endmodule

@@ sv/lbf_div_step.sv @@
// ----------------------------------------------------------------------------
// lbf_div_step: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module lbf_div_step
   import lbf_pkg::*;
#(
   parameter int REM_BITS = DIM_BITS + ASPECT_BITS_DEF,
   parameter int QUO_BITS = COORD_BITS_DEF
) (
   input  logic [REM_BITS-1:0] rem_i,
   input  logic [QUO_BITS-1:0] quo_i,
   input  logic [REM_BITS-1:0] divisor_i,
   output logic [REM_BITS-1:0] rem_o,
   output logic [QUO_BITS-1:0] quo_o
);

   logic [REM_BITS:0] trial;
   logic [REM_BITS:0] diff;
   logic              fits;

   always_comb begin
      trial = {rem_i, quo_i[QUO_BITS-1]};
      diff  = trial - {1'b0, divisor_i};
      fits  = (trial >= {1'b0, divisor_i});
      rem_o = fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
      quo_o = {quo_i[QUO_BITS-2:0], fits};
   end

endmodule
